// ===== design/ltlt_pkg.sv =====
// Shared types, constants and register codes for the leg touchdown latency tracker.
package ltlt_pkg;

    // Sizing of the tracker.
    localparam int LEG_COUNT  = 4;
    localparam int RING_DEPTH = 256;

    // Field widths.
    localparam int TIME_W   = 32;
    localparam int CNT_W    = 32;
    localparam int DEB_W    = 8;
    localparam int TOL_W    = 20;
    localparam int FILL_W   = $clog2(RING_DEPTH + 1);
    localparam int HITS_W   = $clog2(LEG_COUNT + 1);
    localparam int NEW_W    = 3;
    localparam int CFG_AW   = 2;
    localparam int CFG_DW   = 32;

    // Stream word widths, padded to whole bytes.
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 208;

    // Register values after reset.
    localparam logic [DEB_W-1:0]  DEBOUNCE_RST  = 8'd3;
    localparam logic [TIME_W-1:0] TIMEOUT_RST   = 32'd200000;
    localparam logic [TOL_W-1:0]  TOLERANCE_RST = 20'd20000;

    // Configuration register indexes.
    typedef enum logic [CFG_AW-1:0] {
        CFG_DEBOUNCE  = 2'd0,
        CFG_TIMEOUT   = 2'd1,
        CFG_TOLERANCE = 2'd2
    } t_cfg_reg;

    // Operation carried in tuser.
    typedef enum logic {
        OP_UPDATE  = 1'b0,
        OP_RESTART = 1'b1
    } t_op;

    // Tracking state of one leg.
    typedef struct packed {
        logic              prev_expected;
        logic              debounced;
        logic              candidate;
        logic [DEB_W-1:0]  db_count;
        logic [TIME_W-1:0] db_start;
        logic              swing_open;
        logic              expected_seen;
        logic              early_seen;
        logic [TIME_W-1:0] expected_time;
        logic [TIME_W-1:0] early_time;
    } t_leg_state;

    // Leg state after reset or restart: everything clear, expected contact high.
    localparam t_leg_state LEG_RST = '{prev_expected: 1'b1, default: '0};

    // Saturating add of a small hit count to an event counter.
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                                 input logic [HITS_W-1:0] n);
        logic [CNT_W:0] s;
        s = {1'b0, c} + (CNT_W + 1)'(n);
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage

// ===== design/leg_touchdown_latency_tracker_unit.sv =====
// Top level of the leg touchdown latency tracker: debounce, event tracking and counters.
// A word accepted into the input register moves on to the result register, from which it
// can be taken. One word per cycle while the result side takes results; a stall holds the
// input register. Each word passes once through short per-leg logic.
// Reset (synchronous, active low) clears counters, fill level and leg state, sets the
// expected contact history to one for every leg and loads the default register values.
module leg_touchdown_latency_tracker_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input stream.
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // tdata from bit 0: time_us[31:0], exp_contact[3:0], raw_contact[3:0]
    input  logic [ltlt_pkg::IN_DATA_W-1:0]       i_s_axis_tdata,
    // tuser: op
    input  logic                                 i_s_axis_tuser,
    // Result stream.
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // tdata from bit 0: event_total[31:0], on_time_total[31:0], late_total[31:0],
    // early_total[31:0], timeout_total[31:0], sample_count[8:0],
    // debounced_contacts[3:0], new_samples[2:0], newest_latency_us[31:0]
    output logic [ltlt_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,
    // Configuration write port.
    input  logic                                 i_cfg_we,
    input  logic [ltlt_pkg::CFG_AW-1:0]          i_cfg_addr,
    input  logic [ltlt_pkg::CFG_DW-1:0]          i_cfg_wdata
);
    import ltlt_pkg::*;

    // Configuration registers.
    logic [DEB_W-1:0]  r_debounce_samples;
    logic [TIME_W-1:0] r_timeout;
    logic [TOL_W-1:0]  r_tolerance;

    // Input register.
    logic                 r_in_valid;
    t_op                  r_in_op;
    logic [TIME_W-1:0]    r_in_time;
    logic [LEG_COUNT-1:0] r_in_exp;
    logic [LEG_COUNT-1:0] r_in_act;

    // Tracking state; the counters and fill level double as result fields.
    // The sample ring has no readout, so only its fill level is kept.
    t_leg_state        r_leg [LEG_COUNT];
    t_leg_state        n_leg [LEG_COUNT];
    logic [CNT_W-1:0]  r_event, r_on_time, r_late, r_early, r_timeout_cnt;
    logic [CNT_W-1:0]  n_event, n_on_time, n_late, n_early, n_timeout_cnt;
    logic [FILL_W-1:0] r_fill, n_fill;

    // Result-only fields.
    logic                r_out_valid;
    logic [NEW_W-1:0]    r_new, n_new;
    logic [TIME_W-1:0]   r_newest, n_newest;

    // Per-leg outcomes of the current word.
    logic [LEG_COUNT-1:0] res_hit, early_hit, late_hit, on_hit, to_hit;
    logic [TIME_W-1:0]    res_diff [LEG_COUNT];
    logic [HITS_W-1:0]    c_res, c_early, c_late, c_on, c_to;
    logic [LEG_COUNT-1:0] deb_vec;
    logic [FILL_W:0]      fill_sum;

    logic move;

    // The input stage moves forward when the result register is free or being taken.
    assign move            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || move;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_samples <= DEBOUNCE_RST;
            r_timeout          <= TIMEOUT_RST;
            r_tolerance        <= TOLERANCE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                CFG_DEBOUNCE:  r_debounce_samples <= i_cfg_wdata[DEB_W-1:0];
                CFG_TIMEOUT:   r_timeout          <= i_cfg_wdata[TIME_W-1:0];
                CFG_TOLERANCE: r_tolerance        <= i_cfg_wdata[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_op   <= t_op'(i_s_axis_tuser);
            r_in_time <= i_s_axis_tdata[TIME_W-1:0];
            r_in_exp  <= i_s_axis_tdata[TIME_W +: LEG_COUNT];
            r_in_act  <= i_s_axis_tdata[TIME_W + LEG_COUNT +: LEG_COUNT];
        end
    end

    // Per-leg debounce and swing event tracking.
    always_comb begin
        t_leg_state        s;
        logic              actual;
        logic              expected;
        logic              rising;
        logic [TIME_W-1:0] rise_time;
        logic [DEB_W-1:0]  cnt_inc;
        logic signed [TIME_W:0] lat;
        logic signed [TIME_W:0] tol;

        res_hit   = '0;
        to_hit    = '0;
        early_hit = '0;
        late_hit  = '0;
        on_hit    = '0;
        tol       = {{(TIME_W + 1 - TOL_W){1'b0}}, r_tolerance};
        for (int i = 0; i < LEG_COUNT; i++) begin
            s         = r_leg[i];
            actual    = r_in_act[i];
            expected  = r_in_exp[i];
            rising    = 1'b0;
            rise_time = r_in_time;
            cnt_inc   = s.db_count + 1'b1;
            res_diff[i] = '0;

            // Debounce: a run of differing samples switches the contact.
            if (actual == s.debounced) begin
                s.candidate = actual;
                s.db_count  = '0;
            end else if (actual != s.candidate || s.db_count == '0) begin
                s.candidate = actual;
                s.db_count  = DEB_W'(1);
                s.db_start  = r_in_time;
            end else begin
                s.db_count = cnt_inc;
                if (cnt_inc >= r_debounce_samples) begin
                    s.debounced = actual;
                    s.db_count  = '0;
                    rising      = actual;
                    rise_time   = s.db_start;
                end
            end

            // Liftoff in the plan opens an event.
            if (s.prev_expected && !expected) begin
                s.swing_open    = 1'b1;
                s.expected_seen = 1'b0;
                s.early_seen    = 1'b0;
            end

            // Planned touchdown; an early contact resolves right away.
            if (!s.prev_expected && expected && s.swing_open) begin
                s.expected_seen = 1'b1;
                s.expected_time = r_in_time;
                if (s.early_seen) begin
                    res_hit[i]   = 1'b1;
                    res_diff[i]  = s.early_time - r_in_time;
                    s.swing_open = 1'b0;
                end
            end

            // Debounced touchdown: remember it if early, else resolve it once the plan has landed.
            if (rising && s.swing_open) begin
                if (!expected) begin
                    if (!s.early_seen) begin
                        s.early_seen = 1'b1;
                        s.early_time = rise_time;
                    end
                end else if (s.expected_seen) begin
                    res_hit[i]   = 1'b1;
                    res_diff[i]  = rise_time - s.expected_time;
                    s.swing_open = 1'b0;
                end
            end

            // Timeout after the planned touchdown.
            if (s.swing_open && s.expected_seen &&
                (r_in_time - s.expected_time) >= r_timeout) begin
                to_hit[i]    = 1'b1;
                s.swing_open = 1'b0;
            end
            s.prev_expected = expected;
            n_leg[i]        = s;

            // A restart seeds the contacts from the raw bits and clears the rest.
            if (r_in_op == OP_RESTART) begin
                n_leg[i]           = LEG_RST;
                n_leg[i].debounced = r_in_act[i];
                n_leg[i].candidate = r_in_act[i];
            end

            // Classify the latency against the tolerance band.
            lat = {res_diff[i][TIME_W-1], res_diff[i]};
            if (res_hit[i]) begin
                if (lat < -tol) begin
                    early_hit[i] = 1'b1;
                end else if (lat > tol) begin
                    late_hit[i] = 1'b1;
                end else begin
                    on_hit[i] = 1'b1;
                end
            end
        end
    end

    // Hit counts and the newest latency in leg order.
    always_comb begin
        c_res    = '0;
        c_early  = '0;
        c_late   = '0;
        c_on     = '0;
        c_to     = '0;
        n_newest = '0;
        for (int i = 0; i < LEG_COUNT; i++) begin
            c_res   = c_res   + HITS_W'(res_hit[i]);
            c_early = c_early + HITS_W'(early_hit[i]);
            c_late  = c_late  + HITS_W'(late_hit[i]);
            c_on    = c_on    + HITS_W'(on_hit[i]);
            c_to    = c_to    + HITS_W'(to_hit[i]);
            if (res_hit[i]) begin
                n_newest = res_diff[i];
            end
        end
    end

    // Next counters and fill level; a restart clears them.
    always_comb begin
        fill_sum = {1'b0, r_fill} + (FILL_W + 1)'(c_res);
        if (r_in_op == OP_RESTART) begin
            n_event       = '0;
            n_on_time     = '0;
            n_late        = '0;
            n_early       = '0;
            n_timeout_cnt = '0;
            n_fill        = '0;
            n_new         = '0;
        end else begin
            n_event       = sat_add(r_event, HITS_W'(c_res + c_to));
            n_on_time     = sat_add(r_on_time, c_on);
            n_late        = sat_add(r_late, c_late);
            n_early       = sat_add(r_early, c_early);
            n_timeout_cnt = sat_add(r_timeout_cnt, c_to);
            n_fill        = (fill_sum > (FILL_W + 1)'(RING_DEPTH)) ?
                            FILL_W'(RING_DEPTH) : fill_sum[FILL_W-1:0];
            n_new         = NEW_W'(c_res);
        end
    end

    // State and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEG_COUNT; i++) begin
                r_leg[i] <= LEG_RST;
            end
            r_event       <= '0;
            r_on_time     <= '0;
            r_late        <= '0;
            r_early       <= '0;
            r_timeout_cnt <= '0;
            r_fill        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (move) begin
                r_leg         <= n_leg;
                r_event       <= n_event;
                r_on_time     <= n_on_time;
                r_late        <= n_late;
                r_early       <= n_early;
                r_timeout_cnt <= n_timeout_cnt;
                r_fill        <= n_fill;
                r_out_valid   <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_new    <= n_new;
            r_newest <= (r_in_op == OP_RESTART) ? '0 : n_newest;
        end
    end

    // Result word.
    always_comb begin
        for (int i = 0; i < LEG_COUNT; i++) begin
            deb_vec[i] = r_leg[i].debounced;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_newest, r_new, deb_vec, r_fill,
                              r_timeout_cnt, r_early, r_late, r_on_time, r_event};

    // Every event is either classified or a timeout until a counter saturates.
    a_event_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_event != {CNT_W{1'b1}}) |->
        ({2'b00, r_event} == {2'b00, r_on_time} + {2'b00, r_late} +
                             {2'b00, r_early} + {2'b00, r_timeout_cnt}))
        else $error("event total does not match its classes");

    // The fill level never exceeds the ring depth.
    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(RING_DEPTH))
        else $error("ring fill level above depth");

    // A restart word leaves cleared counters behind.
    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && r_in_op == OP_RESTART) |=>
        (r_event == '0 && r_timeout_cnt == '0 && r_fill == '0 && r_new == '0))
        else $error("restart did not clear the tracker");

    // No appended sample means a zero newest latency.
    a_newest_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_new == '0) |-> (r_newest == '0))
        else $error("newest latency set without a new sample");

endmodule

// ===== tb/leg_touchdown_latency_tracker_unit_test.sv =====
// Self-checking testbench for the leg touchdown latency tracker, with its own tracker predictor.
`timescale 1ns / 1ps

module leg_touchdown_latency_tracker_unit_test;
    import ltlt_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int DIRECTED_ROWS = 25;

    // One result word, laid out so that a cast from tdata lines up (first field highest).
    typedef struct packed {
        logic [31:0]       newest;
        logic [NEW_W-1:0]  fresh;
        logic [3:0]        contacts;
        logic [FILL_W-1:0] fill;
        logic [CNT_W-1:0]  timeouts;
        logic [CNT_W-1:0]  early;
        logic [CNT_W-1:0]  late;
        logic [CNT_W-1:0]  on_time;
        logic [CNT_W-1:0]  events;
    } t_tally;

    // A directed stimulus row; rows marked fixed carry a typed result of cleared
    // counters and the given debounced contacts.
    typedef struct packed {
        t_op         op;
        logic [31:0] stamp;
        logic [3:0]  exp_bits;
        logic [3:0]  act_bits;
        logic        fixed;
        logic [3:0]  fixed_contacts;
    } t_stim_row;

    typedef struct packed {
        logic       fixed;
        logic [3:0] contacts;
    } t_pending;

    localparam t_stim_row DIRECTED [0:DIRECTED_ROWS-1] = '{
        // Straight after reset, then a restart seeding all contacts high.
        '{OP_UPDATE,  32'h0000_0000, 4'hF, 4'h0, 1'b1, 4'h0},
        '{OP_RESTART, 32'h0000_0000, 4'hF, 4'hF, 1'b1, 4'hF},
        // Leg 0 swings and lands exactly on time.
        '{OP_UPDATE,  32'd1000,      4'hE, 4'hE, 1'b0, 4'h0},
        '{OP_UPDATE,  32'd2000,      4'hE, 4'hE, 1'b0, 4'h0},
        '{OP_UPDATE,  32'd3000,      4'hE, 4'hE, 1'b0, 4'h0},
        '{OP_UPDATE,  32'd40000,     4'hF, 4'hF, 1'b0, 4'h0},
        '{OP_UPDATE,  32'd41000,     4'hF, 4'hF, 1'b0, 4'h0},
        '{OP_UPDATE,  32'd42000,     4'hF, 4'hF, 1'b0, 4'h0},
        // All legs land early and resolve together in one word.
        '{OP_UPDATE,  32'd50000,     4'h0, 4'h0, 1'b0, 4'h0},
        '{OP_UPDATE,  32'd51000,     4'h0, 4'h0, 1'b0, 4'h0},
        '{OP_UPDATE,  32'd52000,     4'h0, 4'h0, 1'b0, 4'h0},
        '{OP_UPDATE,  32'd60000,     4'h0, 4'hF, 1'b0, 4'h0},
        '{OP_UPDATE,  32'd61000,     4'h0, 4'hF, 1'b0, 4'h0},
        '{OP_UPDATE,  32'd62000,     4'h0, 4'hF, 1'b0, 4'h0},
        '{OP_UPDATE,  32'd100000,    4'hF, 4'hF, 1'b0, 4'h0},
        // Across the time wrap: legs 0 and 1 land late, legs 2 and 3 time out.
        '{OP_RESTART, 32'hFFFF_0000, 4'hF, 4'hF, 1'b1, 4'hF},
        '{OP_UPDATE,  32'hFFFF_1000, 4'h0, 4'h0, 1'b0, 4'h0},
        '{OP_UPDATE,  32'hFFFF_2000, 4'h0, 4'h0, 1'b0, 4'h0},
        '{OP_UPDATE,  32'hFFFF_3000, 4'h0, 4'h0, 1'b0, 4'h0},
        '{OP_UPDATE,  32'hFFFF_FFFF, 4'hF, 4'h0, 1'b0, 4'h0},
        '{OP_UPDATE,  32'h0000_8000, 4'hF, 4'h3, 1'b0, 4'h0},
        '{OP_UPDATE,  32'h0000_9000, 4'hF, 4'h3, 1'b0, 4'h0},
        '{OP_UPDATE,  32'h0000_A000, 4'hF, 4'h3, 1'b0, 4'h0},
        '{OP_UPDATE,  32'h0004_0000, 4'hF, 4'h3, 1'b0, 4'h0},
        '{OP_RESTART, 32'hFFFF_FFFF, 4'h0, 4'h0, 1'b1, 4'h0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic                  i_s_axis_tuser = 1'b0;
    logic                  i_m_axis_tready = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_AW-1:0]     i_cfg_addr = '0;
    logic [CFG_DW-1:0]     i_cfg_wdata = '0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    // Predictor copy of the registers and tracking state.
    logic [DEB_W-1:0]  debounce_cfg;
    logic [TIME_W-1:0] timeout_cfg;
    logic [TOL_W-1:0]  tolerance_cfg;
    t_leg_state        legs [LEG_COUNT];
    logic [CNT_W-1:0]  events_cnt, on_time_cnt, late_cnt, early_cnt, timeouts_cnt;
    logic [FILL_W-1:0] ring_fill;

    t_tally   tally_q [$];
    t_pending pending_q [$];

    int  cycle_count = 0;
    int  mismatches = 0;
    int  words_sent = 0;
    int  words_checked = 0;
    int  latencies_seen = 0;
    int  timeouts_seen = 0;
    int  settings_used = 1;
    bit  calm = 1'b0;

    // Gait generator state for the random part.
    bit  gait_exp [LEG_COUNT];
    bit  gait_act [LEG_COUNT];
    int  exp_next [LEG_COUNT];
    int  fall_at [LEG_COUNT];
    int  rise_at [LEG_COUNT];
    int  gait_idx = 0;
    logic [31:0] gait_now = '0;

    leg_touchdown_latency_tracker_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // Clock generation.
    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    function automatic logic [CNT_W-1:0] sat_bump(input logic [CNT_W-1:0] c);
        return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

    // Most gaps are short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Clear counters, fill level and leg state; the expected history starts high.
    task automatic clear_tracker();
        for (int i = 0; i < LEG_COUNT; i++) begin
            legs[i] = '0;
            legs[i].prev_expected = 1'b1;
        end
        events_cnt   = '0;
        on_time_cnt  = '0;
        late_cnt     = '0;
        early_cnt    = '0;
        timeouts_cnt = '0;
        ring_fill    = '0;
    endtask

    // Classify one resolved latency and append it to the sample ring.
    task automatic log_latency(input logic [31:0] diff, inout t_tally r);
        longint lat;
        longint tol;
        lat = longint'(signed'(diff));
        tol = longint'(tolerance_cfg);
        events_cnt = sat_bump(events_cnt);
        if (lat < -tol) begin
            early_cnt = sat_bump(early_cnt);
        end else if (lat > tol) begin
            late_cnt = sat_bump(late_cnt);
        end else begin
            on_time_cnt = sat_bump(on_time_cnt);
        end
        if (ring_fill < RING_DEPTH) begin
            ring_fill = ring_fill + 1'b1;
        end
        r.fresh  = r.fresh + 1'b1;
        r.newest = diff;
        latencies_seen++;
    endtask

    // Advance the tracker by one input word and form the result word it yields.
    task automatic track_word(input t_op op, input logic [31:0] now, input logic [3:0] ex,
                              input logic [3:0] ac, output t_tally r);
        logic        rising;
        logic [31:0] rise_t;
        logic [31:0] elapsed;
        r = '0;
        if (op == OP_RESTART) begin
            clear_tracker();
            for (int i = 0; i < LEG_COUNT; i++) begin
                legs[i].debounced = ac[i];
                legs[i].candidate = ac[i];
            end
        end else begin
            for (int i = 0; i < LEG_COUNT; i++) begin
                rising = 1'b0;
                rise_t = now;
                // Debounce: a run of differing samples switches the contact.
                if (ac[i] == legs[i].debounced) begin
                    legs[i].candidate = ac[i];
                    legs[i].db_count  = '0;
                end else if (ac[i] != legs[i].candidate || legs[i].db_count == 0) begin
                    legs[i].candidate = ac[i];
                    legs[i].db_count  = 8'd1;
                    legs[i].db_start  = now;
                end else begin
                    legs[i].db_count = legs[i].db_count + 1'b1;
                    if (legs[i].db_count >= debounce_cfg) begin
                        legs[i].debounced = ac[i];
                        legs[i].db_count  = '0;
                        rising = ac[i];
                        rise_t = legs[i].db_start;
                    end
                end
                // Expected contact falling opens a swing event.
                if (legs[i].prev_expected && !ex[i]) begin
                    legs[i].swing_open    = 1'b1;
                    legs[i].expected_seen = 1'b0;
                    legs[i].early_seen    = 1'b0;
                end
                // Expected touchdown; an early contact resolves right away.
                if (!legs[i].prev_expected && ex[i] && legs[i].swing_open) begin
                    legs[i].expected_seen = 1'b1;
                    legs[i].expected_time = now;
                    if (legs[i].early_seen) begin
                        log_latency(legs[i].early_time - legs[i].expected_time, r);
                        legs[i].swing_open = 1'b0;
                    end
                end
                // Debounced touchdown.
                if (rising && legs[i].swing_open) begin
                    if (!ex[i]) begin
                        if (!legs[i].early_seen) begin
                            legs[i].early_seen = 1'b1;
                            legs[i].early_time = rise_t;
                        end
                    end else if (legs[i].expected_seen) begin
                        log_latency(rise_t - legs[i].expected_time, r);
                        legs[i].swing_open = 1'b0;
                    end
                end
                // Timeout after the expected touchdown.
                elapsed = now - legs[i].expected_time;
                if (legs[i].swing_open && legs[i].expected_seen &&
                    elapsed >= timeout_cfg) begin
                    events_cnt   = sat_bump(events_cnt);
                    timeouts_cnt = sat_bump(timeouts_cnt);
                    legs[i].swing_open = 1'b0;
                    timeouts_seen++;
                end
                legs[i].prev_expected = ex[i];
            end
        end
        for (int i = 0; i < LEG_COUNT; i++) begin
            r.contacts[i] = legs[i].debounced;
        end
        r.events   = events_cnt;
        r.on_time  = on_time_cnt;
        r.late     = late_cnt;
        r.early    = early_cnt;
        r.timeouts = timeouts_cnt;
        r.fill     = ring_fill;
    endtask

    // Cycle counter.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Checks result words, tracks register writes and predicts each accepted word.
    always @(posedge i_clk) begin : scoreboard
        t_tally   got;
        t_tally   want;
        t_tally   predicted;
        t_pending p;
        if (!i_rst_n) begin
            debounce_cfg  = DEBOUNCE_RST;
            timeout_cfg   = TIMEOUT_RST;
            tolerance_cfg = TOLERANCE_RST;
            clear_tracker();
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = t_tally'(o_m_axis_tdata);
                words_checked++;
                if (tally_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result word %0d at cycle %0d", words_checked,
                                 cycle_count);
                    end
                end else begin
                    want = tally_q.pop_front();
                    if (got.events !== want.events || got.on_time !== want.on_time ||
                        got.late !== want.late || got.early !== want.early ||
                        got.timeouts !== want.timeouts || got.fill !== want.fill ||
                        got.contacts !== want.contacts || got.fresh !== want.fresh ||
                        got.newest !== want.newest) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch in result word %0d at cycle %0d", words_checked,
                                     cycle_count);
                            $write("  expected ev %0d ot %0d lt %0d er %0d to %0d",
                                   want.events, want.on_time, want.late, want.early,
                                   want.timeouts);
                            $display(" fill %0d deb %h new %0d lat %h",
                                     want.fill, want.contacts, want.fresh, want.newest);
                            $write("  actual   ev %0d ot %0d lt %0d er %0d to %0d",
                                   got.events, got.on_time, got.late, got.early,
                                   got.timeouts);
                            $display(" fill %0d deb %h new %0d lat %h",
                                     got.fill, got.contacts, got.fresh, got.newest);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_addr))
                    CFG_DEBOUNCE:  debounce_cfg  = i_cfg_wdata[DEB_W-1:0];
                    CFG_TIMEOUT:   timeout_cfg   = i_cfg_wdata[TIME_W-1:0];
                    CFG_TOLERANCE: tolerance_cfg = i_cfg_wdata[TOL_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                p = pending_q.pop_front();
                track_word(t_op'(i_s_axis_tuser), i_s_axis_tdata[31:0], i_s_axis_tdata[35:32],
                           i_s_axis_tdata[39:36], predicted);
                if (p.fixed) begin
                    want = '0;
                    want.contacts = p.contacts;
                    tally_q.insert(tally_q.size(), want);
                end else begin
                    tally_q.insert(tally_q.size(), predicted);
                end
            end
        end
    end

    // Result side: random stalls, except in calm stretches.
    initial begin : result_sink
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                i_m_axis_tready <= 1'b0;
                hold--;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                hold = pick_gap();
                if (hold > 0) begin
                    i_m_axis_tready <= 1'b0;
                    hold--;
                end else begin
                    i_m_axis_tready <= 1'b1;
                end
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Present one input word after a random gap and hold it until accepted.
    task automatic push_word(input t_op op, input logic [31:0] now, input logic [3:0] ex,
                             input logic [3:0] ac, input logic fixed,
                             input logic [3:0] fixed_contacts);
        int       gap;
        t_pending pend;
        gap = calm ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pend.fixed    = fixed;
        pend.contacts = fixed_contacts;
        pending_q.insert(pending_q.size(), pend);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {ac, ex, now};
        i_s_axis_tuser  <= op;
        words_sent++;
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
    endtask

    // Drain all results, let the pipeline settle, then load a new register setting.
    task automatic apply_setting(input logic [7:0] deb, input logic [31:0] tout,
                                 input logic [19:0] tol);
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (tally_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_DEBOUNCE;
        i_cfg_wdata <= {24'd0, deb};
        @(negedge i_clk);
        i_cfg_addr  <= CFG_TIMEOUT;
        i_cfg_wdata <= tout;
        @(negedge i_clk);
        i_cfg_addr  <= CFG_TOLERANCE;
        i_cfg_wdata <= {12'd0, tol};
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Random part: per-leg gait with swing and touchdown scheduled around the plan,
    // mixed with contact bounce, noise words, time jumps and occasional restarts.
    task automatic run_gait(input int count);
        int          db_eff;
        int          period;
        logic [3:0]  ex;
        logic [3:0]  ac;
        logic [31:0] stamp;
        t_op         op;
        for (int k = 0; k < count; k++) begin
            if (k % 50 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
            end
            db_eff = (debounce_cfg == 0) ? 1 : int'(debounce_cfg);
            if ($urandom_range(0, 29) == 0) begin
                gait_now = $urandom;
            end else begin
                gait_now = gait_now + $urandom_range(0, 15000);
            end
            for (int i = 0; i < LEG_COUNT; i++) begin
                if (gait_idx >= exp_next[i]) begin
                    gait_exp[i] = !gait_exp[i];
                    period = $urandom_range(2, 2 * db_eff + 8);
                    exp_next[i] = gait_idx + period;
                    if (!gait_exp[i]) begin
                        fall_at[i] = gait_idx + $urandom_range(0, period / 2);
                        rise_at[i] = fall_at[i] + db_eff + $urandom_range(0, period + 6);
                    end
                end
                if (fall_at[i] >= 0 && gait_idx >= fall_at[i]) begin
                    gait_act[i] = 1'b0;
                    fall_at[i] = -1;
                end
                if (rise_at[i] >= 0 && gait_idx >= rise_at[i]) begin
                    gait_act[i] = 1'b1;
                    rise_at[i] = -1;
                end
                ex[i] = gait_exp[i];
                ac[i] = gait_act[i] ^ ($urandom_range(0, 24) == 0);
            end
            stamp = gait_now;
            op = OP_UPDATE;
            if ($urandom_range(0, 9) == 0) begin
                ex = 4'($urandom_range(0, 15));
                ac = 4'($urandom_range(0, 15));
                if ($urandom_range(0, 3) == 0) begin
                    stamp = $urandom;
                end
            end
            if ($urandom_range(0, 49) == 0) begin
                op = OP_RESTART;
            end
            push_word(op, stamp, ex, ac, 1'b0, 4'h0);
            gait_idx++;
        end
    endtask

    // Stimulus sequence.
    initial begin : stimulus
        for (int i = 0; i < LEG_COUNT; i++) begin
            gait_exp[i] = 1'b1;
            gait_act[i] = 1'b1;
            exp_next[i] = $urandom_range(0, 6);
            fall_at[i]  = -1;
            rise_at[i]  = -1;
        end
        gait_now = $urandom;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows under the reset register values.
        for (int n = 0; n < DIRECTED_ROWS; n++) begin
            push_word(DIRECTED[n].op, DIRECTED[n].stamp, DIRECTED[n].exp_bits,
                      DIRECTED[n].act_bits, DIRECTED[n].fixed, DIRECTED[n].fixed_contacts);
        end
        run_gait(110);

        // Zero timeout and zero tolerance.
        apply_setting(8'd1, 32'd0, 20'd0);
        run_gait(90);
        // Maximum debounce and timeout, with a wide tolerance.
        apply_setting(8'd255, 32'hFFFF_FFFF, 20'd1000000);
        run_gait(40);
        // Debounce of zero.
        apply_setting(8'd0, 32'd50000, 20'd5000);
        run_gait(90);
        repeat (3) begin
            apply_setting(8'($urandom_range(1, 6)), 32'($urandom_range(10000, 400000)),
                          20'($urandom_range(0, 60000)));
            run_gait(75);
        end

        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (tally_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (tally_q.size() != 0 || pending_q.size() != 0) begin
            mismatches++;
        end
        $display("Sent %0d words over %0d register settings, checked %0d result words.",
                 words_sent, settings_used, words_checked);
        $display("Predicted %0d latency samples and %0d timeouts; %0d mismatches.",
                 latencies_seen, timeouts_seen, mismatches);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog on the cycle counter.
    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Run stopped at the cycle limit with %0d results outstanding.", tally_q.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
